>>> rtl/bpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpb_pkg
// shared types, register indexes and mask helpers for the pixel converter
// ----------------------------------------------------------------------------
package bpb_pkg;

  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned REM_W   = 40;
  localparam int unsigned QUO_W   = 8;

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  localparam logic [2:0] REG_RED_MASK    = 3'd0;
  localparam logic [2:0] REG_GREEN_MASK  = 3'd1;
  localparam logic [2:0] REG_BLUE_MASK   = 3'd2;
  localparam logic [2:0] REG_ALPHA_MASK  = 3'd3;
  localparam logic [2:0] REG_ALPHA_EN    = 3'd4;
  localparam logic [2:0] REG_BYTES_PIX   = 3'd5;

  localparam logic [2:0] BPP_FULL = 3'd4;
  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic [7:0] HALF_ROUND = 8'd127;

  typedef struct packed {
    logic [NUM_CH-1:0][REM_W-1:0] rem;
    logic [NUM_CH-1:0][QUO_W-1:0] quo;
  } cell_data_t;

  typedef struct packed {
    logic [NUM_CH-1:0] chan_ok;
    logic              flat_en;
    logic              bad;
  } flat_cfg_t;

  // count of trailing zero bits, 31 at most
  function automatic logic [4:0] trail_zeros(input logic [31:0] m);
    logic [4:0] tz;
    tz = 5'd31;
    for (int i = 30; i >= 0; i--) begin
      if (m[i]) tz = 5'(i);
    end
    return tz;
  endfunction

  // zero or a single run of ones
  function automatic logic mask_ok(input logic [31:0] m);
    logic [31:0] filled;
    filled = (m | (m - 32'd1)) + 32'd1;
    return (filled & m) == 32'd0;
  endfunction

endpackage

>>> rtl/bpb_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpb_div_cell
// one restoring-division step for all four channels, one quotient bit
// ----------------------------------------------------------------------------
module bpb_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  bpb_pkg::cell_data_t                    in_data,
  input  logic [bpb_pkg::NUM_CH-1:0][31:0]       divisor,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output bpb_pkg::cell_data_t                    out_data
);

  logic                valid;
  bpb_pkg::cell_data_t data;
  bpb_pkg::cell_data_t data_next;

  always_comb begin
    logic [bpb_pkg::REM_W-1:0] trial;
    data_next = in_data;
    for (int ch = 0; ch < bpb_pkg::NUM_CH; ch++) begin
      trial = bpb_pkg::REM_W'(divisor[ch]) << BIT;
      if (in_data.rem[ch] >= trial) begin
        data_next.rem[ch]      = in_data.rem[ch] - trial;
        data_next.quo[ch][BIT] = 1'b1;
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data <= data_next;
    end
  end

endmodule

>>> rtl/bpb_flat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpb_flat
// masks unusable channels, composites over white and holds the output word
// ----------------------------------------------------------------------------
module bpb_flat (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpb_pkg::cell_data_t in_data,
  input  bpb_pkg::flat_cfg_t  cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic                flattened,
  output logic                bad_masks
);

  logic                   valid;
  logic [2:0][7:0]        col_next;
  logic                   flat_next;

  always_comb begin
    logic [7:0]  a;
    logic [7:0]  c;
    logic [16:0] x;
    logic [16:0] y;
    a = cfg.chan_ok[bpb_pkg::CH_ALPHA] ? in_data.quo[bpb_pkg::CH_ALPHA] : 8'd0;
    flat_next = cfg.flat_en && (a != bpb_pkg::FULL_SCALE);
    for (int ch = 0; ch < 3; ch++) begin
      c = cfg.chan_ok[ch] ? in_data.quo[ch] : 8'd0;
      x = 17'(c) * 17'(a)
        + 17'(bpb_pkg::FULL_SCALE) * 17'(bpb_pkg::FULL_SCALE - a)
        + 17'(bpb_pkg::HALF_ROUND);
      // divide by 255, exact below 65535
      y = (x + 17'(x[16:8]) + 17'd1) >> 8;
      col_next[ch] = flat_next ? y[7:0] : c;
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      red       <= col_next[bpb_pkg::CH_RED];
      green     <= col_next[bpb_pkg::CH_GREEN];
      blue      <= col_next[bpb_pkg::CH_BLUE];
      flattened <= flat_next;
      bad_masks <= cfg.bad;
    end
  end

endmodule

>>> rtl/bitfield_pixel_to_bgr24.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitfield_pixel_to_bgr24
// bit-field pixel word to 8-bit red, green and blue with flattening over white
// ----------------------------------------------------------------------------
// usage:
//   pixel words enter on in_valid/in_ready, one word per cycle while out_ready holds.
//   each word is split by the four channel masks, then rescaled to 8 bits by
//   a chain of eight division cells, one quotient bit each, working on all
//   four channels side by side.
//   results leave on out_valid/out_ready with red, green, blue, flattened and
//   bad_masks. the path is registered in one entry register, eight cells and the
//   flattening/output register.
//   every stage holds its word only while the next one is full and stalled,
//   so words keep entering until the whole chain is full; a stalled receiver
//   eventually drops in_ready.
//   the masks, alpha enable and pixel size are written through cfg_we, cfg_index
//   and cfg_data; the user must write them only while no word is in flight, which the block leaves to the user.
//   reset empties the chain and loads 8-8-8 masks, no alpha, 3 bytes a pixel.
// ----------------------------------------------------------------------------
module bitfield_pixel_to_bgr24 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        flattened,
  output logic        bad_masks
);

  localparam int unsigned NCELL = bpb_pkg::QUO_W;

  logic [bpb_pkg::NUM_CH-1:0][31:0] mask;
  logic                             alpha_enable;
  logic [2:0]                       bytes_per_pixel;

  logic [bpb_pkg::NUM_CH-1:0][31:0] mx;
  logic [bpb_pkg::NUM_CH-1:0][4:0]  tz;
  bpb_pkg::flat_cfg_t               fcfg;
  bpb_pkg::cell_data_t              entry_next;

  logic                             sv   [NCELL+1];
  logic                             sr   [NCELL+1];
  bpb_pkg::cell_data_t              sd   [NCELL+1];
  logic                             flat_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask[bpb_pkg::CH_RED]   <= 32'h00ff0000;
      mask[bpb_pkg::CH_GREEN] <= 32'h0000ff00;
      mask[bpb_pkg::CH_BLUE]  <= 32'h000000ff;
      mask[bpb_pkg::CH_ALPHA] <= 32'h0;
      alpha_enable            <= 1'b0;
      bytes_per_pixel         <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        bpb_pkg::REG_RED_MASK:   mask[bpb_pkg::CH_RED]   <= cfg_data;
        bpb_pkg::REG_GREEN_MASK: mask[bpb_pkg::CH_GREEN] <= cfg_data;
        bpb_pkg::REG_BLUE_MASK:  mask[bpb_pkg::CH_BLUE]  <= cfg_data;
        bpb_pkg::REG_ALPHA_MASK: mask[bpb_pkg::CH_ALPHA] <= cfg_data;
        bpb_pkg::REG_ALPHA_EN:   alpha_enable            <= cfg_data[0];
        bpb_pkg::REG_BYTES_PIX:  bytes_per_pixel         <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // derived channel settings, stable while words are in flight if the registers are left unwritten
  always_comb begin
    logic [31:0] pix;
    logic [31:0] v;
    logic        ovl;
    pix = (bytes_per_pixel == bpb_pkg::BPP_FULL) ? pixel : {8'h00, pixel[23:0]};
    fcfg.bad = 1'b0;
    for (int ch = 0; ch < bpb_pkg::NUM_CH; ch++) begin
      tz[ch] = bpb_pkg::trail_zeros(mask[ch]);
      mx[ch] = mask[ch] >> tz[ch];
      fcfg.chan_ok[ch] = (mask[ch] != 32'd0) && bpb_pkg::mask_ok(mask[ch]);
      if (!bpb_pkg::mask_ok(mask[ch])) fcfg.bad = 1'b1;
      v = (pix & mask[ch]) >> tz[ch];
      // numerator v*255 + max/2
      entry_next.rem[ch] = ({v, 8'h00} - {8'h00, v}) + {9'h000, mx[ch][31:1]};
      entry_next.quo[ch] = '0;
    end
    if (mask[bpb_pkg::CH_RED] == 32'd0 || mask[bpb_pkg::CH_GREEN] == 32'd0
        || mask[bpb_pkg::CH_BLUE] == 32'd0) fcfg.bad = 1'b1;
    ovl = ((mask[bpb_pkg::CH_RED] & mask[bpb_pkg::CH_GREEN])
         | (mask[bpb_pkg::CH_RED] & mask[bpb_pkg::CH_BLUE])
         | (mask[bpb_pkg::CH_GREEN] & mask[bpb_pkg::CH_BLUE])
         | (mask[bpb_pkg::CH_ALPHA] & (mask[bpb_pkg::CH_RED] | mask[bpb_pkg::CH_GREEN]
            | mask[bpb_pkg::CH_BLUE]))) != 32'd0;
    if (ovl) fcfg.bad = 1'b1;
    fcfg.flat_en = alpha_enable && fcfg.chan_ok[bpb_pkg::CH_ALPHA];
  end

  // entry register
  assign in_ready = !sv[0] || sr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (in_ready) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      sd[0] <= entry_next;
    end
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    bpb_div_cell #(
      .BIT(NCELL - 1 - g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[g]),
      .in_ready  (sr[g]),
      .in_data   (sd[g]),
      .divisor   (mx),
      .out_valid (sv[g+1]),
      .out_ready ((g == NCELL - 1) ? flat_ready : sr[g+1]),
      .out_data  (sd[g+1])
    );
  end

  assign sr[NCELL] = flat_ready;

  bpb_flat u_flat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sv[NCELL]),
    .in_ready  (flat_ready),
    .in_data   (sd[NCELL]),
    .cfg       (fcfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .flattened (flattened),
    .bad_masks (bad_masks)
  );

  a_flat_needs_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid && flattened |-> alpha_enable)
    else $error("flattened word without alpha enabled");

  a_flat_not_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && flattened |-> red != 8'd0 && green != 8'd0 && blue != 8'd0)
    else $error("flattened color reached zero");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the bit-field pixel converter against a local predictor: directed
// mask and alpha cases, then random words under sender idling, receiver stalls and
// several register settings
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       flattened;
    logic       bad_masks;
  } bgr_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] pixel;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        flattened;
  logic        bad_masks;

  bitfield_pixel_to_bgr24 u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .red(red), .green(green), .blue(blue),
    .flattened(flattened), .bad_masks(bad_masks)
  );

  // predictor copy of the registers
  logic [31:0] m_red, m_green, m_blue, m_alpha;
  logic        a_en;
  logic [2:0]  bpp;

  bgr_word_t   expected_bgr[$];
  int          errors;
  int          send_idle_pct;
  int          recv_stall_pct;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic logic run_ok(input logic [31:0] m);
    logic [31:0] v;
    int s;
    s = 0;
    if (m == 0) return 1'b1;
    while (s < 31 && m[s] == 1'b0) s++;
    v = m >> s;
    return (v & (v + 32'd1)) == 0;
  endfunction

  function automatic logic [7:0] scale_chan(input logic [31:0] m, input logic [31:0] p);
    logic [63:0] v, mx;
    int s;
    s = 0;
    if (m == 0 || !run_ok(m)) return 8'd0;
    while (s < 31 && m[s] == 1'b0) s++;
    mx = 64'(m >> s);
    v = 64'((p & m) >> s);
    return 8'((v * 255 + mx / 2) / mx);
  endfunction

  function automatic logic [7:0] over_white(input logic [7:0] c, input logic [7:0] a);
    int unsigned t;
    t = (c * a + 255 * (255 - a) + 127) / 255;
    return 8'(t);
  endfunction

  function automatic bgr_word_t convert_pixel(input logic [31:0] p_in);
    bgr_word_t r;
    logic [31:0] p;
    logic [7:0] a;
    p = (bpp == bpb_pkg::BPP_FULL) ? p_in : (p_in & 32'h00ffffff);
    r.red = scale_chan(m_red, p);
    r.green = scale_chan(m_green, p);
    r.blue = scale_chan(m_blue, p);
    r.flattened = 1'b0;
    if (a_en && m_alpha != 0 && run_ok(m_alpha)) begin
      a = scale_chan(m_alpha, p);
      if (a != 8'd255) begin
        r.flattened = 1'b1;
        r.red = over_white(r.red, a);
        r.green = over_white(r.green, a);
        r.blue = over_white(r.blue, a);
      end
    end
    r.bad_masks = !run_ok(m_red) || !run_ok(m_green) || !run_ok(m_blue) ||
                  !run_ok(m_alpha) || m_red == 0 || m_green == 0 || m_blue == 0 ||
                  ((m_red & m_green) | (m_red & m_blue) | (m_green & m_blue) |
                   (m_alpha & (m_red | m_green | m_blue))) != 0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    bgr_word_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_bgr.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_bgr.pop_front();
          if (red !== want.red) report_mismatch("red", red, want.red);
          if (green !== want.green) report_mismatch("green", green, want.green);
          if (blue !== want.blue) report_mismatch("blue", blue, want.blue);
          if (flattened !== want.flattened)
            report_mismatch("flattened", flattened, want.flattened);
          if (bad_masks !== want.bad_masks)
            report_mismatch("bad_masks", bad_masks, want.bad_masks);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays up between words unless the sender idles
  task automatic send_pixel(input logic [31:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_bgr.push_back(convert_pixel(p));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_bgr.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      bpb_pkg::REG_RED_MASK:   m_red = val;
      bpb_pkg::REG_GREEN_MASK: m_green = val;
      bpb_pkg::REG_BLUE_MASK:  m_blue = val;
      bpb_pkg::REG_ALPHA_MASK: m_alpha = val;
      bpb_pkg::REG_ALPHA_EN:   a_en = val[0];
      bpb_pkg::REG_BYTES_PIX:  bpp = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_masks(input logic [31:0] r, input logic [31:0] g,
                           input logic [31:0] b, input logic [31:0] a,
                           input logic en, input logic [2:0] bp);
    drain();
    write_reg(bpb_pkg::REG_RED_MASK, r);
    write_reg(bpb_pkg::REG_GREEN_MASK, g);
    write_reg(bpb_pkg::REG_BLUE_MASK, b);
    write_reg(bpb_pkg::REG_ALPHA_MASK, a);
    write_reg(bpb_pkg::REG_ALPHA_EN, {31'd0, en});
    write_reg(bpb_pkg::REG_BYTES_PIX, {29'd0, bp});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_run;
    int lo, w;
    w = $urandom_range(32, 1);
    lo = $urandom_range(32 - w);
    return (w == 32) ? 32'hffffffff : (((32'd1 << w) - 1) << lo);
  endfunction

  // directed: reset masks, extremes, opaque and clear alpha, broken masks
  task automatic test_directed;
    send_pixel(32'h00000000);
    send_pixel(32'hffffffff);
    send_pixel(32'h12345678);
    set_masks(32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'hff000000, 1'b1, 3'd4);
    send_pixel(32'hff804020);
    send_pixel(32'h00804020);
    send_pixel(32'h80ffffff);
    send_pixel(32'h7f000000);
    set_masks(32'h0000f800, 32'h000007e0, 32'h0000001f, 32'h0, 1'b1, 3'd3);
    send_pixel(32'hffffffff);
    send_pixel(32'h0000ffff);
    send_pixel(32'h00001234);
    set_masks(32'h00f0f000, 32'h0000ff00, 32'h0, 32'h80000001, 1'b1, 3'd7);
    send_pixel(32'hffffffff);
    send_pixel(32'hdeadbeef);
    set_masks(32'hffffffff, 32'h00000001, 32'h80000000, 32'h00000002, 1'b1, 3'd4);
    send_pixel(32'hffffffff);
    send_pixel(32'h00000002);
    send_pixel(32'h80000001);
    set_masks(32'h00000f00, 32'h000000f0, 32'h0000000f, 32'h0000f000, 1'b1, 3'd0);
    send_pixel(32'h0000ffff);
    send_pixel(32'h00007abc);
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    logic [31:0] a;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        a = ($urandom_range(3) == 0) ? 32'd0 : rand_run();
        if ($urandom_range(4) == 0)
          set_masks($urandom(), rand_run(), rand_run(), $urandom(), 1'($urandom()),
                    3'($urandom()));
        else
          set_masks(rand_run(), rand_run(), rand_run(), a, $urandom_range(3) != 0,
                    $urandom_range(1) ? 3'd4 : 3'd3);
      end
      send_pixel($urandom());
    end
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = bpb_pkg::REG_RED_MASK;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel = '0;
    out_ready = 1'b1;
    m_red = 32'h00ff0000;
    m_green = 32'h0000ff00;
    m_blue = 32'h000000ff;
    m_alpha = 32'h0;
    a_en = 1'b0;
    bpp = 3'd3;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(450, 0, 0);
    test_random(400, 75, 0);
    test_random(400, 0, 75);
    test_random(450, 19, 19);
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
